>>> rtl/core/lavm_pkg.sv
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Shared vector types, side-band record and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lavm_pkg;

  // Lane 0 is x, lane 1 is y, lane 2 is z.
  typedef logic [2:0][31:0] vec32_t;
  typedef logic [2:0][63:0] vec64_t;

  // Items that ride alongside a vector through the normalisation unit.
  typedef struct packed {
    vec32_t eye;
    vec32_t up;
    vec32_t rz;
    logic   deg;
  } side_t;

  localparam int unsigned RotFrac = 30;
  localparam logic [1:0]  RowLast = 2'd2;

  localparam logic [31:0] Int32Max = 32'h7fff_ffff;
  localparam logic [31:0] Int32Min = 32'h8000_0000;

endpackage

`default_nettype wire

>>> rtl/core/lavm_norm.sv
// ----------------------------------------------------------------------------
// Pipelined vector normalisation
// Scales a 3-vector to Q2.30 unit length: block-float alignment, sum of
// squares, a single 32-stage square root and a 32-stage restoring divider per lane.
// ----------------------------------------------------------------------------
`default_nettype none

module lavm_norm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  lavm_pkg::vec64_t  vec_i,
  input  lavm_pkg::side_t   side_i,
  output logic              valid_o,
  output lavm_pkg::vec32_t  vec_o,
  output logic              zero_o,
  output lavm_pkg::side_t   side_o
);

  localparam int unsigned SqSteps  = 32;
  localparam int unsigned DivSteps = 32;

  typedef struct packed {
    logic [63:0]      x;
    logic [63:0]      res;
    logic [2:0][29:0] mag;
    logic [2:0]       neg;
    logic             zero;
    lavm_pkg::side_t  side;
  } sq_t;

  typedef struct packed {
    logic [2:0][61:0] rem;
    logic [2:0][31:0] quo;
    logic [31:0]      n;
    logic [2:0]       neg;
    logic             zero;
    lavm_pkg::side_t  side;
  } dv_t;

  function automatic logic [5:0] msb_pos(logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  function automatic sq_t sqrt_step(sq_t s, int k);
    logic [63:0] step_bit;
    logic [63:0] trial;
    sq_t         r;
    step_bit = 64'd1 << (62 - 2 * k);
    trial    = s.res + step_bit;
    r        = s;
    if (s.x >= trial) begin
      r.x   = s.x - trial;
      r.res = (s.res >> 1) + step_bit;
    end else begin
      r.res = s.res >> 1;
    end
    return r;
  endfunction

  function automatic dv_t div_step(dv_t s, int i);
    logic [62:0] dvs;
    logic [4:0]  j;
    dv_t         r;
    j   = 5'(31 - i);
    r   = s;
    dvs = 63'(s.n) << j;
    for (int l = 0; l < 3; l++) begin
      if ({1'b0, s.rem[l]} >= dvs) begin
        r.rem[l]    = s.rem[l] - dvs[61:0];
        r.quo[l][j] = 1'b1;
      end
    end
    return r;
  endfunction

  // Alignment stages.
  logic             a_v_q, b_v_q, c_v_q, d_v_q, e_v_q;
  logic [2:0][63:0] a_mag_q, b_mag_q, c_mag_q;
  logic [2:0]       a_neg_q, b_neg_q, c_neg_q, d_neg_q, e_neg_q;
  lavm_pkg::side_t  a_side_q, b_side_q, c_side_q, d_side_q, e_side_q;
  logic [63:0]      b_m_q;
  logic [5:0]       c_pos_q;
  logic             c_zero_q, d_zero_q, e_zero_q;
  logic [2:0][29:0] d_mag_q, e_mag_q;
  logic [2:0][59:0] e_sq_q;

  logic [2:0][63:0] a_mag_d;
  logic [63:0]      b_m_d;
  logic [2:0][29:0] d_mag_d;
  logic [63:0]      sh;

  // Root and divider stages.
  sq_t              sq_q [0:SqSteps];
  sq_t              sq_n [0:SqSteps-1];
  logic [SqSteps:0] sq_v_q;
  dv_t              dv_q [0:DivSteps];
  dv_t              dv_n [0:DivSteps-1];
  logic [DivSteps:0] dv_v_q;
  dv_t              dv_start;

  logic             o_v_q;
  lavm_pkg::vec32_t o_vec_q;
  logic             o_zero_q;
  lavm_pkg::side_t  o_side_q;
  lavm_pkg::vec32_t o_vec_d;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      a_mag_d[l] = vec_i[l][63] ? (64'd0 - vec_i[l]) : vec_i[l];
    end
  end

  always_comb begin
    b_m_d = a_mag_q[0];
    if (a_mag_q[1] > b_m_d) b_m_d = a_mag_q[1];
    if (a_mag_q[2] > b_m_d) b_m_d = a_mag_q[2];
  end

  always_comb begin
    sh = '0;
    for (int l = 0; l < 3; l++) begin
      if (c_pos_q >= 6'd29) begin
        sh = c_mag_q[l] >> (c_pos_q - 6'd29);
      end else begin
        sh = c_mag_q[l] << (6'd29 - c_pos_q);
      end
      d_mag_d[l] = sh[29:0];
    end
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    assign sq_n[k] = sqrt_step(sq_q[k], k);
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    assign dv_n[i] = div_step(dv_q[i], i);
  end

  always_comb begin
    dv_start      = '0;
    dv_start.n    = sq_q[SqSteps].res[31:0];
    dv_start.neg  = sq_q[SqSteps].neg;
    dv_start.zero = sq_q[SqSteps].zero;
    dv_start.side = sq_q[SqSteps].side;
    for (int l = 0; l < 3; l++) begin
      dv_start.rem[l] = (62'(sq_q[SqSteps].mag[l]) << lavm_pkg::RotFrac)
                        + 62'(sq_q[SqSteps].res[31:1]);
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_q[DivSteps].zero) begin
        o_vec_d[l] = '0;
      end else if (dv_q[DivSteps].neg[l]) begin
        o_vec_d[l] = 32'd0 - dv_q[DivSteps].quo[l];
      end else begin
        o_vec_d[l] = dv_q[DivSteps].quo[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      c_v_q  <= 1'b0;
      d_v_q  <= 1'b0;
      e_v_q  <= 1'b0;
      sq_v_q <= '0;
      dv_v_q <= '0;
      o_v_q  <= 1'b0;
    end else if (en_i) begin
      a_v_q  <= valid_i;
      b_v_q  <= a_v_q;
      c_v_q  <= b_v_q;
      d_v_q  <= c_v_q;
      e_v_q  <= d_v_q;
      sq_v_q <= {sq_v_q[SqSteps-1:0], e_v_q};
      dv_v_q <= {dv_v_q[DivSteps-1:0], sq_v_q[SqSteps]};
      o_v_q  <= dv_v_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mag_q  <= a_mag_d;
      for (int l = 0; l < 3; l++) a_neg_q[l] <= vec_i[l][63];
      a_side_q <= side_i;

      b_mag_q  <= a_mag_q;
      b_m_q    <= b_m_d;
      b_neg_q  <= a_neg_q;
      b_side_q <= a_side_q;

      c_mag_q  <= b_mag_q;
      c_pos_q  <= msb_pos(b_m_q);
      c_zero_q <= (b_m_q == 64'd0);
      c_neg_q  <= b_neg_q;
      c_side_q <= b_side_q;

      d_mag_q  <= d_mag_d;
      d_zero_q <= c_zero_q;
      d_neg_q  <= c_neg_q;
      d_side_q <= c_side_q;

      for (int l = 0; l < 3; l++) e_sq_q[l] <= 60'(d_mag_q[l]) * 60'(d_mag_q[l]);
      e_mag_q  <= d_mag_q;
      e_zero_q <= d_zero_q;
      e_neg_q  <= d_neg_q;
      e_side_q <= d_side_q;

      sq_q[0].x    <= 64'(e_sq_q[0]) + 64'(e_sq_q[1]) + 64'(e_sq_q[2]);
      sq_q[0].res  <= '0;
      sq_q[0].mag  <= e_mag_q;
      sq_q[0].neg  <= e_neg_q;
      sq_q[0].zero <= e_zero_q;
      sq_q[0].side <= e_side_q;
      for (int k = 0; k < SqSteps; k++) sq_q[k+1] <= sq_n[k];

      dv_q[0] <= dv_start;
      for (int i = 0; i < DivSteps; i++) dv_q[i+1] <= dv_n[i];

      o_vec_q  <= o_vec_d;
      o_zero_q <= dv_q[DivSteps].zero;
      o_side_q <= dv_q[DivSteps].side;
    end
  end

  assign valid_o = o_v_q;
  assign vec_o   = o_vec_q;
  assign zero_o  = o_zero_q;
  assign side_o  = o_side_q;

endmodule

`default_nettype wire

>>> rtl/core/look_at_view_matrix_core.sv
// Rows: the first row of an item is followed by the other two in the next
// cycles unless stalled.
// Throughput: the single output channel carries three row beats per item and
// so sets the input rate; the pipeline itself takes one a cycle when not halted.
// Reset: rst_ni clears all valid bits and the row counter; no clearing pass.
// ----------------------------------------------------------------------------
// Look-at view matrix core
// Builds the three rows of a fixed-point look-at view matrix from an eye
// point, a target point and an up vector, one row per output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, up_x, up_y, up_z (32 bits each)
  input  logic [287:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // rot_a, rot_b, rot_c, shift (32 bits each)
  output logic [127:0] m_axis_tdata_o,
  // row_index (2 bits), degenerate (1 bit)
  output logic [2:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  // The stages of the up-axis cross product carry this record.
  typedef struct packed {
    lavm_pkg::vec32_t eye;
    lavm_pkg::vec32_t rz;
    lavm_pkg::vec32_t rx;
    logic             deg;
  } frame_t;

  // Low 64 bits of a signed 34 x 32 product; the translation sum wraps.
  function automatic logic [63:0] smul(logic [33:0] a, logic [31:0] b);
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    sa = 64'($signed(a));
    sb = 64'($signed(b));
    return 64'(sa * sb);
  endfunction

  function automatic logic [33:0] sx34(logic [31:0] v);
    return 34'($signed(v));
  endfunction

  // The whole pipeline moves together; it halts only when the last stage
  // holds an item that the row serialiser cannot yet take.
  logic en;
  logic take;

  // Input stage: eye minus aim.
  logic             p0_v_q;
  lavm_pkg::vec64_t p0_d_q;
  lavm_pkg::side_t  p0_side_q;
  lavm_pkg::vec32_t in_eye, in_aim, in_up;

  // First normalisation gives the back axis z.
  logic             n1_v, n1_zero;
  lavm_pkg::vec32_t n1_vec;
  lavm_pkg::side_t  n1_side;

  // Cross product up x z.
  logic             x1_v_q, x2_v_q;
  logic [5:0][63:0] x1_p_q;
  lavm_pkg::side_t  x1_side_q, x2_side_q;
  lavm_pkg::vec64_t x2_c_q;

  // Second normalisation gives the right axis x.
  logic             n2_v, n2_zero;
  lavm_pkg::vec32_t n2_vec;
  lavm_pkg::side_t  n2_side;

  // Cross product z x x with rounding gives the up axis y.
  logic             y1_v_q, y2_v_q, y3_v_q, y4_v_q;
  frame_t           y1_f_q, y2_f_q, y3_f_q, y4_f_q;
  logic [5:0][63:0] y1_p_q;
  logic [2:0][63:0] y2_d_q, y3_mag_q;
  logic [2:0]       y3_neg_q;
  logic [2:0][33:0] y4_ry_q;
  frame_t           y1_f_d;
  logic [2:0][63:0] y3_mag_d;
  logic [2:0][34:0] y4_r;
  logic [2:0][33:0] y4_ry_d;

  // Translations: minus each axis dotted with the eye point.
  logic                  t1_v_q, t2_v_q, t3_v_q, t4_v_q;
  logic [2:0][2:0][63:0] t1_p_q;
  logic [2:0][2:0][31:0] t1_rot_q, t2_rot_q, t3_rot_q, t4_rot_q;
  logic                  t1_deg_q, t2_deg_q, t3_deg_q, t4_deg_q;
  logic [2:0][63:0]      t2_acc_q, t3_mag_q;
  logic [2:0]            t3_neg_q;
  logic [2:0][31:0]      t4_shift_q;
  logic [2:0][2:0][33:0] rows;
  logic [2:0][2:0][63:0] t1_p_d;
  logic [2:0][2:0][31:0] t1_rot_d;
  logic [2:0][63:0]      t3_nd;
  logic [2:0][63:0]      t3_mag_d;
  logic [2:0][34:0]      t4_r;
  logic [2:0][31:0]      t4_shift_d;

  // Row serialiser, which is also the output register.
  logic                  ser_v_q;
  logic [1:0]            ser_row_q;
  logic [2:0][2:0][31:0] ser_rot_q;
  logic [2:0][31:0]      ser_shift_q;
  logic                  ser_deg_q;

  assign take = !ser_v_q || (m_axis_tready_i && (ser_row_q == lavm_pkg::RowLast));
  assign en   = take || !t4_v_q;
  assign s_axis_tready_o = en;

  assign in_eye = s_axis_tdata_i[95:0];
  assign in_aim = s_axis_tdata_i[191:96];
  assign in_up  = s_axis_tdata_i[287:192];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        p0_d_q[l] <= 64'($signed(in_eye[l])) - 64'($signed(in_aim[l]));
      end
      p0_side_q.eye <= in_eye;
      p0_side_q.up  <= in_up;
      p0_side_q.rz  <= '0;
      p0_side_q.deg <= 1'b0;
    end
  end

  lavm_norm u_norm_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p0_v_q),
    .vec_i   (p0_d_q),
    .side_i  (p0_side_q),
    .valid_o (n1_v),
    .vec_o   (n1_vec),
    .zero_o  (n1_zero),
    .side_o  (n1_side)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_p_q[0] <= smul(sx34(n1_side.up[1]), n1_vec[2]);
      x1_p_q[1] <= smul(sx34(n1_side.up[2]), n1_vec[1]);
      x1_p_q[2] <= smul(sx34(n1_side.up[2]), n1_vec[0]);
      x1_p_q[3] <= smul(sx34(n1_side.up[0]), n1_vec[2]);
      x1_p_q[4] <= smul(sx34(n1_side.up[0]), n1_vec[1]);
      x1_p_q[5] <= smul(sx34(n1_side.up[1]), n1_vec[0]);
      x1_side_q.eye <= n1_side.eye;
      x1_side_q.up  <= n1_side.up;
      x1_side_q.rz  <= n1_vec;
      x1_side_q.deg <= n1_zero;

      x2_c_q[0] <= x1_p_q[0] - x1_p_q[1];
      x2_c_q[1] <= x1_p_q[2] - x1_p_q[3];
      x2_c_q[2] <= x1_p_q[4] - x1_p_q[5];
      x2_side_q <= x1_side_q;
    end
  end

  lavm_norm u_norm_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (x2_v_q),
    .vec_i   (x2_c_q),
    .side_i  (x2_side_q),
    .valid_o (n2_v),
    .vec_o   (n2_vec),
    .zero_o  (n2_zero),
    .side_o  (n2_side)
  );

  always_comb begin
    y1_f_d.eye = n2_side.eye;
    y1_f_d.rz  = n2_side.rz;
    y1_f_d.rx  = n2_vec;
    y1_f_d.deg = n2_side.deg || n2_zero;
  end

  // Round half away from zero on the shift by the rotation fraction.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      y3_mag_d[l] = y2_d_q[l][63] ? (64'd0 - y2_d_q[l]) : y2_d_q[l];
      y4_r[l]     = 35'((65'(y3_mag_q[l]) + (65'd1 << (lavm_pkg::RotFrac - 1)))
                        >> lavm_pkg::RotFrac);
      y4_ry_d[l]  = y3_neg_q[l] ? 34'(35'd0 - y4_r[l]) : y4_r[l][33:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y1_p_q[0] <= smul(sx34(n2_side.rz[1]), n2_vec[2]);
      y1_p_q[1] <= smul(sx34(n2_side.rz[2]), n2_vec[1]);
      y1_p_q[2] <= smul(sx34(n2_side.rz[2]), n2_vec[0]);
      y1_p_q[3] <= smul(sx34(n2_side.rz[0]), n2_vec[2]);
      y1_p_q[4] <= smul(sx34(n2_side.rz[0]), n2_vec[1]);
      y1_p_q[5] <= smul(sx34(n2_side.rz[1]), n2_vec[0]);
      y1_f_q    <= y1_f_d;

      y2_d_q[0] <= y1_p_q[0] - y1_p_q[1];
      y2_d_q[1] <= y1_p_q[2] - y1_p_q[3];
      y2_d_q[2] <= y1_p_q[4] - y1_p_q[5];
      y2_f_q    <= y1_f_q;

      y3_mag_q <= y3_mag_d;
      for (int l = 0; l < 3; l++) y3_neg_q[l] <= y2_d_q[l][63];
      y3_f_q   <= y2_f_q;

      y4_ry_q <= y4_ry_d;
      y4_f_q  <= y3_f_q;
    end
  end

  // Row 0 is the right axis, row 1 the up axis, row 2 the back axis.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rows[0][l] = sx34(y4_f_q.rx[l]);
      rows[1][l] = y4_ry_q[l];
      rows[2][l] = sx34(y4_f_q.rz[l]);
    end
    for (int k = 0; k < 3; k++) begin
      for (int l = 0; l < 3; l++) begin
        t1_p_d[k][l]   = smul(rows[k][l], y4_f_q.eye[l]);
        t1_rot_d[k][l] = rows[k][l][31:0];
      end
    end
  end

  // The translation is the rounded, saturated shift of minus the dot product, whose
  // magnitude is the wrapped dot product itself when its negation is negative.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t3_nd[k]    = 64'd0 - t2_acc_q[k];
      t3_mag_d[k] = t3_nd[k][63] ? t2_acc_q[k] : t3_nd[k];
      t4_r[k]     = 35'((65'(t3_mag_q[k]) + (65'd1 << (lavm_pkg::RotFrac - 1)))
                        >> lavm_pkg::RotFrac);
      if (t3_neg_q[k]) begin
        if (t4_r[k] > 35'(lavm_pkg::Int32Min)) begin
          t4_shift_d[k] = lavm_pkg::Int32Min;
        end else begin
          t4_shift_d[k] = 32'(35'd0 - t4_r[k]);
        end
      end else begin
        if (t4_r[k] > 35'(lavm_pkg::Int32Max)) begin
          t4_shift_d[k] = lavm_pkg::Int32Max;
        end else begin
          t4_shift_d[k] = t4_r[k][31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_p_q   <= t1_p_d;
      t1_rot_q <= t1_rot_d;
      t1_deg_q <= y4_f_q.deg;

      for (int k = 0; k < 3; k++) begin
        t2_acc_q[k] <= t1_p_q[k][0] + t1_p_q[k][1] + t1_p_q[k][2];
      end
      t2_rot_q <= t1_rot_q;
      t2_deg_q <= t1_deg_q;

      t3_mag_q <= t3_mag_d;
      for (int k = 0; k < 3; k++) t3_neg_q[k] <= t3_nd[k][63];
      t3_rot_q <= t2_rot_q;
      t3_deg_q <= t2_deg_q;

      t4_shift_q <= t4_shift_d;
      t4_rot_q   <= t3_rot_q;
      t4_deg_q   <= t3_deg_q;
    end
  end

  // Valid bits for the stages held in this module.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
      x1_v_q <= 1'b0;
      x2_v_q <= 1'b0;
      y1_v_q <= 1'b0;
      y2_v_q <= 1'b0;
      y3_v_q <= 1'b0;
      y4_v_q <= 1'b0;
      t1_v_q <= 1'b0;
      t2_v_q <= 1'b0;
      t3_v_q <= 1'b0;
      t4_v_q <= 1'b0;
    end else if (en) begin
      p0_v_q <= s_axis_tvalid_i;
      x1_v_q <= n1_v;
      x2_v_q <= x1_v_q;
      y1_v_q <= n2_v;
      y2_v_q <= y1_v_q;
      y3_v_q <= y2_v_q;
      y4_v_q <= y3_v_q;
      t1_v_q <= y4_v_q;
      t2_v_q <= t1_v_q;
      t3_v_q <= t2_v_q;
      t4_v_q <= t3_v_q;
    end
  end

  // The serialiser loads a whole item and sends its rows one beat at a time;
  // it takes the next item in the cycle that its last row is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q   <= 1'b0;
      ser_row_q <= '0;
    end else if (take) begin
      ser_v_q   <= t4_v_q;
      ser_row_q <= '0;
    end else if (m_axis_tready_i) begin
      ser_row_q <= ser_row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ser_rot_q   <= t4_rot_q;
      ser_shift_q <= t4_shift_q;
      ser_deg_q   <= t4_deg_q;
    end
  end

  assign m_axis_tvalid_o = ser_v_q;
  assign m_axis_tdata_o  = {ser_shift_q[ser_row_q], ser_rot_q[ser_row_q]};
  assign m_axis_tuser_o  = {ser_deg_q, ser_row_q};
  assign m_axis_tlast_o  = (ser_row_q == lavm_pkg::RowLast);

endmodule

`default_nettype wire

>>> tb/look_at_view_matrix_checker.sv
// ----------------------------------------------------------------------------
// Look-at view matrix checker
// Watches both stream channels, predicts the three matrix rows of every
// accepted input beat and compares each output beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [287:0] s_axis_tdata_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [127:0] m_axis_tdata_i,
  input  logic [2:0]   m_axis_tuser_i,
  input  logic         m_axis_tlast_i,
  output int unsigned  fail_count_o,
  output int unsigned  rows_pending_o
);

  typedef struct packed {
    logic [1:0]  row;
    logic [31:0] rot_a;
    logic [31:0] rot_b;
    logic [31:0] rot_c;
    logic [31:0] shift;
    logic        deg;
    logic        last;
  } view_row_t;

  view_row_t rows_q[$];
  int unsigned fail_count;
  int unsigned rows_pending;

  assign fail_count_o   = fail_count;
  assign rows_pending_o = rows_pending;

  function automatic longint round_sh30(longint v);
    logic [63:0] m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (lavm_pkg::RotFrac - 1))) >> lavm_pkg::RotFrac;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] sqrt_floor(logic [63:0] x);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Returns 1 when every component is zero.
  function automatic logic unit_vec(input longint v[3], output longint u[3]);
    logic [63:0] mag[3];
    logic [63:0] mx, total, n, q;
    mx = 0;
    total = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b1;
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      mx = mx << 1;
    end
    for (int i = 0; i < 3; i++) total += mag[i] * mag[i];
    n = sqrt_floor(total);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << lavm_pkg::RotFrac) + (n >> 1)) / n;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] eye_offset(input longint ax[3], input longint e[3]);
    longint dot, t;
    dot = 0;
    for (int i = 0; i < 3; i++) dot += ax[i] * e[i];  // wraps like 64-bit hardware
    t = round_sh30(-dot);
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  task automatic predict_rows(logic [287:0] d);
    longint eye[3], aim[3], up[3], dv[3], cv[3], rx[3], ry[3], rz[3];
    logic deg;
    view_row_t r;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(d[32*i +: 32]));
      aim[i] = longint'($signed(d[32*(3+i) +: 32]));
      up[i]  = longint'($signed(d[32*(6+i) +: 32]));
      dv[i]  = eye[i] - aim[i];
    end
    deg = unit_vec(dv, rz);
    cv[0] = up[1] * rz[2] - up[2] * rz[1];
    cv[1] = up[2] * rz[0] - up[0] * rz[2];
    cv[2] = up[0] * rz[1] - up[1] * rz[0];
    if (unit_vec(cv, rx)) deg = 1'b1;
    ry[0] = round_sh30(rz[1] * rx[2] - rz[2] * rx[1]);
    ry[1] = round_sh30(rz[2] * rx[0] - rz[0] * rx[2]);
    ry[2] = round_sh30(rz[0] * rx[1] - rz[1] * rx[0]);
    for (int k = 0; k < 3; k++) begin
      longint ax[3];
      for (int i = 0; i < 3; i++) begin
        if (k == 0) ax[i] = rx[i];
        else if (k == 1) ax[i] = ry[i];
        else ax[i] = rz[i];
      end
      r.row   = k[1:0];
      r.rot_a = ax[0][31:0];
      r.rot_b = ax[1][31:0];
      r.rot_c = ax[2][31:0];
      r.shift = eye_offset(ax, eye);
      r.deg   = deg;
      r.last  = (k[1:0] == lavm_pkg::RowLast);
      rows_q.push_back(r);
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial rows_pending = 0;

  always @(posedge clk_i) begin
    view_row_t w;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) predict_rows(s_axis_tdata_i);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (rows_q.size() == 0) begin
          report("unexpected row beat", {30'd0, m_axis_tuser_i[1:0]}, 32'd0);
        end else begin
          w = rows_q.pop_front();
          if (m_axis_tuser_i[1:0] != w.row) report("row_index", m_axis_tuser_i[1:0], w.row);
          if (m_axis_tdata_i[31:0] != w.rot_a) report("rot_a", m_axis_tdata_i[31:0], w.rot_a);
          if (m_axis_tdata_i[63:32] != w.rot_b) report("rot_b", m_axis_tdata_i[63:32], w.rot_b);
          if (m_axis_tdata_i[95:64] != w.rot_c) report("rot_c", m_axis_tdata_i[95:64], w.rot_c);
          if (m_axis_tdata_i[127:96] != w.shift)
            report("shift", m_axis_tdata_i[127:96], w.shift);
          if (m_axis_tuser_i[2] != w.deg) report("degenerate", m_axis_tuser_i[2], w.deg);
          if (m_axis_tlast_i != w.last) report("last_row", m_axis_tlast_i, w.last);
        end
      end
      rows_pending = rows_q.size();
    end
  end

endmodule

`default_nettype wire

>>> tb/look_at_view_matrix_core_tb.sv
// ----------------------------------------------------------------------------
// Look-at view matrix testbench
// Drives directed and random camera set-ups under varying back-pressure and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix_core_tb;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [287:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;
  int unsigned  fail_count, rows_pending;

  int send_idle = 0;   // percent
  int recv_idle = 0;
  bit hold_off = 0;

  always #1 clk_i = ~clk_i;

  look_at_view_matrix_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata),
    .m_axis_tuser_o(m_tuser), .m_axis_tlast_o(m_tlast)
  );

  look_at_view_matrix_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_i(m_tdata),
    .m_axis_tuser_i(m_tuser), .m_axis_tlast_i(m_tlast),
    .fail_count_o(fail_count), .rows_pending_o(rows_pending)
  );

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(negedge clk_i) begin
    if (hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_fffc + $urandom_range(3);
      2: return $urandom_range(7) - 3;
      3: return {{14{$urandom_range(1) == 1}}, 18'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Offers one beat, holding tvalid across back-to-back beats.
  task automatic send_beat(logic [287:0] d);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [287:0] pack_set(logic [31:0] e[3], logic [31:0] a[3],
                                            logic [31:0] u[3]);
    return {u[2], u[1], u[0], a[2], a[1], a[0], e[2], e[1], e[0]};
  endfunction

  task automatic random_set();
    logic [31:0] e[3], a[3], u[3];
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      e[i] = pick_coord();
      a[i] = (kind == 0) ? e[i] : pick_coord();
      u[i] = pick_coord();
    end
    // Up parallel to the view direction gives a nearly zero cross product.
    if (kind == 1) for (int i = 0; i < 3; i++) u[i] = e[i] - a[i];
    if (kind == 2) for (int i = 0; i < 3; i++) u[i] = 0;
    send_beat(pack_set(e, a, u));
  endtask

  localparam logic [31:0] One = 32'h0001_0000;

  initial begin
    logic [31:0] e[3], a[3], u[3];
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: plain camera, extremes, eye on target, up along view, zero up.
    e = '{0, 0, 5*One}; a = '{0, 0, 0}; u = '{0, One, 0};
    send_beat(pack_set(e, a, u));
    e = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    a = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    u = '{32'h8000_0000, 32'h7fff_ffff, 0};
    send_beat(pack_set(e, a, u));
    send_beat(pack_set(a, e, e));
    e = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    send_beat(pack_set(e, a, '{32'hffff_ffff, 0, 1}));
    send_beat(pack_set(e, e, u));
    e = '{One, 2*One, 3*One}; a = '{0, 0, 0};
    send_beat(pack_set(e, a, e));
    send_beat(pack_set(e, a, '{0, 0, 0}));
    send_beat(pack_set('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}));
    send_beat(pack_set('{1, 0, 0}, '{0, 0, 0}, '{0, 0, 1}));
    send_beat(pack_set('{32'h8000_0000, 0, 0}, '{32'h7fff_ffff, 0, 0}, '{0, 1, 0}));
    for (int i = 0; i < 8; i++) random_set();

    // Long receiver hold-off: more beats are offered than the pipeline holds,
    // so it fills and stalls its input before the hold-off ends.
    hold_off = 1;
    fork
      for (int i = 0; i < 200; i++) random_set();
      repeat (400) @(negedge clk_i);
    join_any
    hold_off = 0;
    wait fork;

    send_idle = 15; recv_idle = 86;
    for (int i = 0; i < 100; i++) random_set();
    send_idle = 86; recv_idle = 15;
    for (int i = 0; i < 100; i++) random_set();
    send_idle = 0; recv_idle = 0;
    for (int i = 0; i < 90; i++) random_set();
    s_tvalid <= 1'b0;

    while (rows_pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
